### hdl/number_to_rect_rasterizer_macros.svh
// ----------------------------------------------------------------------------
// Number to rectangle rasterizer: assertion macros
// Shared concurrent assertion forms used by the top level.
// ----------------------------------------------------------------------------
`ifndef NUMBER_TO_RECT_RASTERIZER_MACROS_SVH
`define NUMBER_TO_RECT_RASTERIZER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define NRR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define NRR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/nrr_pkg.sv
// ----------------------------------------------------------------------------
// Number to rectangle rasterizer: package
// Types, widths, bar tables and scaling constants shared by all modules.
// ----------------------------------------------------------------------------
package nrr_pkg;

   localparam int DIM_W      = 13;
   localparam int NUMBER_W   = 31;
   localparam int POS_W      = 16;
   localparam int SIZE_W     = 15;
   localparam int COLOR_W    = 32;
   localparam int CURSOR_W   = 22;
   localparam int EDGE_W     = 24;
   localparam int NUM_W      = 38;
   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 88;
   localparam int CSR_ADDR_W = 3;

   localparam logic [DIM_W-1:0] DIM_MAX     = 13'd4096;
   localparam logic [DIM_W-1:0] WIDTH_RST   = 13'd1280;
   localparam logic [DIM_W-1:0] HEIGHT_RST  = 13'd720;
   localparam logic [14:0]      HALF_SCREEN = 15'd25600;

   // floor(x/100) = (x*RECIP100) >> 28 for x < 2^21
   localparam logic [21:0] RECIP100 = 22'd2684355;
   // floor(v/10) = (v*RECIP10) >> 35 for v < 2^32
   localparam logic [31:0] RECIP10  = 32'hCCCCCCCD;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   // CSR register indexes
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   typedef struct packed {
      logic [3:0]          digit;
      logic [CURSOR_W-1:0] cursor;
      logic                last_digit;
      logic [POS_W-1:0]    pos_x;
      logic [POS_W-1:0]    pos_y;
      logic [SIZE_W-1:0]   size;
      logic [COLOR_W-1:0]  color;
   } digit_entry_type;

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic [DIM_W-1:0] scale;
   } dims_type;

   // Edge coefficients per bar in half size units: x lo, x hi, y lo, y hi
   typedef logic signed [3:0] coef_type;
   typedef struct packed {
      coef_type xlo;
      coef_type xhi;
      coef_type ylo;
      coef_type yhi;
   } bar_coef_type;

   localparam bar_coef_type BAR_V_L = '{-4'sd3, -4'sd1, -4'sd5, 4'sd5};
   localparam bar_coef_type BAR_V_R = '{ 4'sd1,  4'sd3, -4'sd5, 4'sd5};
   localparam bar_coef_type BAR_T_N = '{-4'sd1,  4'sd1,  4'sd3, 4'sd5};
   localparam bar_coef_type BAR_B_N = '{-4'sd1,  4'sd1, -4'sd5, -4'sd3};
   localparam bar_coef_type BAR_T_W = '{-4'sd3,  4'sd3,  4'sd3, 4'sd5};
   localparam bar_coef_type BAR_B_W = '{-4'sd3,  4'sd3, -4'sd5, -4'sd3};
   localparam bar_coef_type BAR_M_W = '{-4'sd3,  4'sd3, -4'sd1, 4'sd1};
   localparam bar_coef_type BAR_RU  = '{ 4'sd1,  4'sd3, -4'sd1, 4'sd5};
   localparam bar_coef_type BAR_LD  = '{-4'sd3, -4'sd1, -4'sd5, 4'sd1};
   localparam bar_coef_type BAR_LU  = '{-4'sd3, -4'sd1, -4'sd1, 4'sd5};
   localparam bar_coef_type BAR_RD  = '{ 4'sd1,  4'sd3, -4'sd5, 4'sd1};

   localparam bar_coef_type BAR_TABLE [39] = '{
      BAR_V_L, BAR_V_R, BAR_T_N, BAR_B_N,
      BAR_V_R,
      BAR_T_W, BAR_B_W, BAR_M_W, BAR_RU, BAR_LD,
      BAR_V_R, BAR_T_W, BAR_B_W, BAR_M_W,
      BAR_V_R, BAR_LU, BAR_M_W,
      BAR_T_W, BAR_B_W, BAR_M_W, BAR_LU, BAR_RD,
      BAR_V_L, BAR_T_W, BAR_B_W, BAR_M_W, BAR_RD,
      BAR_V_R, BAR_T_W,
      BAR_V_L, BAR_V_R, BAR_T_N, BAR_B_N, BAR_M_W,
      BAR_V_R, BAR_T_W, BAR_B_W, BAR_M_W, BAR_LU
   };

   localparam logic [5:0] BAR_FIRST [10] = '{6'd0, 6'd4, 6'd5, 6'd10, 6'd14,
                                             6'd17, 6'd22, 6'd27, 6'd29, 6'd34};
   localparam logic [2:0] BAR_COUNT [10] = '{3'd4, 3'd1, 3'd5, 3'd4, 3'd3,
                                             3'd5, 3'd5, 3'd2, 3'd5, 3'd5};

endpackage

### hdl/nrr_front.sv
// ----------------------------------------------------------------------------
// Number to rectangle rasterizer: front end
// Accepts a number and splits it into decimal digits, one per cycle while
// the queue has room, tagging each with its cursor offset and the item's drawing parameters.
// ----------------------------------------------------------------------------
module nrr_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [nrr_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                            push,
   output nrr_pkg::digit_entry_type        push_data,
   input  logic                            push_ready
);
   import nrr_pkg::*;

   logic                busy_ff, busy_in;
   logic [NUMBER_W-1:0] value_ff, value_in;
   logic [CURSOR_W-1:0] cursor_ff, cursor_in;
   logic [POS_W-1:0]    pos_x_ff, pos_y_ff;
   logic [SIZE_W-1:0]   size_ff;
   logic [COLOR_W-1:0]  color_ff;

   logic [63:0]         prod;
   logic [NUMBER_W-1:0] quot;
   logic [3:0]          digit;
   logic [CURSOR_W-1:0] step;
   logic                accept;

   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && req_tready;

   // Divide by ten with a reciprocal multiply
   assign prod  = {33'd0, value_ff} * {32'd0, RECIP10};
   assign quot  = {3'd0, prod[62:35]};
   assign digit = 4'(value_ff - ({quot[NUMBER_W-4:0], 3'd0} + {quot[NUMBER_W-2:0], 1'b0}));
   assign step  = (digit == 4'd1) ? {5'd0, size_ff, 2'd0} : {4'd0, size_ff, 3'd0};

   assign push = busy_ff;
   always_comb begin
      push_data.digit      = digit;
      push_data.cursor     = cursor_ff;
      push_data.last_digit = (quot == '0);
      push_data.pos_x      = pos_x_ff;
      push_data.pos_y      = pos_y_ff;
      push_data.size       = size_ff;
      push_data.color      = color_ff;
   end

   // Digit sequencing
   always_comb begin
      busy_in   = busy_ff;
      value_in  = value_ff;
      cursor_in = cursor_ff;
      if (accept) begin
         busy_in   = 1'b1;
         value_in  = req_tdata[NUMBER_W-1:0];
         cursor_in = '0;
      end else if (busy_ff && push_ready) begin
         value_in  = quot;
         cursor_in = cursor_ff + step;
         if (quot == '0) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      cursor_ff <= cursor_in;
      if (accept) begin
         pos_x_ff <= req_tdata[46:31];
         pos_y_ff <= req_tdata[62:47];
         size_ff  <= req_tdata[77:63];
         color_ff <= req_tdata[109:78];
      end
   end

endmodule

### hdl/nrr_queue.sv
// ----------------------------------------------------------------------------
// Number to rectangle rasterizer: digit queue
// Small FIFO of digit entries between the front end and the back end.
// ----------------------------------------------------------------------------
module nrr_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  nrr_pkg::digit_entry_type   push_data,
   output logic                       push_ready,
   input  logic                       pop,
   output nrr_pkg::digit_entry_type   pop_data,
   output logic                       pop_valid
);
   import nrr_pkg::*;

   digit_entry_type    slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]    count_ff;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != QPTR_W'(0) + (QPTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_data   = slot_ff[rd_ptr_ff];

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (do_push && !do_pop)      count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push) count_ff <= count_ff - 1'b1;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

### hdl/nrr_back.sv
// ----------------------------------------------------------------------------
// Number to rectangle rasterizer: back end
// Walks the bars of each digit and maps their edges to clamped pixel
// coordinates through a three-stage pipeline, one rectangle per cycle unless stalled.
// ----------------------------------------------------------------------------
module nrr_back (
   input  logic                            clock,
   input  logic                            reset,
   input  nrr_pkg::dims_type               dims,
   input  logic                            entry_valid,
   input  nrr_pkg::digit_entry_type        entry,
   output logic                            entry_pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [nrr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast
);
   import nrr_pkg::*;

   logic               adv, issue, last_bar;
   logic [2:0]         bar_ff, bar_in;
   bar_coef_type       coef;
   logic [5:0]         tbl_idx;
   logic signed [EDGE_W-1:0] base_x, base_y;
   logic signed [EDGE_W-1:0] e_in [4];

   logic                      v1_ff, v2_ff, v3_ff;
   logic signed [EDGE_W-1:0]  e_ff [4];
   logic signed [NUM_W-1:0]   n_ff [4];
   logic [DIM_W-1:0]          p_ff [4];
   logic [COLOR_W-1:0]        c1_ff, c2_ff, c3_ff;
   logic                      l1_ff, l2_ff, l3_ff;

   logic [26:0]               off_w, off_h;
   logic signed [NUM_W-1:0]   n_in [4];
   logic [DIM_W-1:0]          p_in [4];

   assign adv      = !v3_ff || rsp_tready;
   assign issue    = entry_valid && adv;
   assign last_bar = (bar_ff == BAR_COUNT[entry.digit] - 3'd1);
   assign entry_pop = issue && last_bar;
   assign bar_in   = issue ? (last_bar ? 3'd0 : bar_ff + 3'd1) : bar_ff;

   // Bar sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         bar_ff <= '0;
      end else begin
         bar_ff <= bar_in;
      end
   end

   // Stage 1: edge positions in half game units (positions sign-extended)
   assign tbl_idx = BAR_FIRST[entry.digit] + {3'd0, bar_ff};
   assign coef    = BAR_TABLE[tbl_idx];
   assign base_x  = EDGE_W'($signed({entry.pos_x, 1'b0}))
                    - $signed({2'd0, entry.cursor});
   assign base_y  = EDGE_W'($signed({entry.pos_y, 1'b0}));
   always_comb begin
      e_in[0] = base_x + EDGE_W'(coef.xlo * $signed({1'b0, entry.size}));
      e_in[1] = base_x + EDGE_W'(coef.xhi * $signed({1'b0, entry.size}));
      e_in[2] = base_y + EDGE_W'(coef.ylo * $signed({1'b0, entry.size}));
      e_in[3] = base_y + EDGE_W'(coef.yhi * $signed({1'b0, entry.size}));
   end

   // Stage 2: scale and recentre
   assign off_w = dims.width  * HALF_SCREEN;
   assign off_h = dims.height * HALF_SCREEN;
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         n_in[i] = NUM_W'(e_ff[i] * $signed({1'b0, dims.scale}))
                   + $signed({11'd0, (i < 2) ? off_w : off_h});
      end
   end

   // Stage 3: divide by 51200 and clamp
   always_comb begin
      logic [20:0] x;
      logic [42:0] pr;
      logic [14:0] q;
      logic [DIM_W-1:0] lim;
      for (int i = 0; i < 4; i++) begin
         x   = n_ff[i][29:9];
         pr  = {22'd0, x} * {21'd0, RECIP100};
         q   = pr[42:28];
         lim = (i < 2) ? dims.width : dims.height;
         if (n_ff[i][NUM_W-1])          p_in[i] = '0;
         else if (q > {2'd0, lim})      p_in[i] = lim;
         else                           p_in[i] = q[DIM_W-1:0];
      end
   end

   // Pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      if (adv) begin
         e_ff  <= e_in;
         c1_ff <= entry.color;
         l1_ff <= entry.last_digit && last_bar;
         n_ff  <= n_in;
         c2_ff <= c1_ff;
         l2_ff <= l1_ff;
         p_ff  <= p_in;
         c3_ff <= c2_ff;
         l3_ff <= l2_ff;
      end
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tlast  = l3_ff;
   assign rsp_tdata  = {4'd0, c3_ff, p_ff[3], p_ff[2], p_ff[1], p_ff[0]};

endmodule

### hdl/number_to_rect_rasterizer.sv
// ----------------------------------------------------------------------------
// Number to rectangle rasterizer: top level
// Draws the decimal digits of a number as clipped pixel rectangles.
// ----------------------------------------------------------------------------
// Usage:
//   req_* channel takes one number with its position, stroke size and color.
//   rsp_* channel returns one rectangle per bar, least significant digit
//   first; rsp_tlast marks the final rectangle of the number.
//   csr_* APB port holds screen_width (0x0) and screen_height (0x4); write
//   only while the block is idle. The low 13 bits of a write saturate to 1..4096.
// Timing:
//   The front end peels one digit per cycle (one multiply by 1/10) into a
//   four-entry queue while it has room; the back end emits one rectangle
//   per cycle through a three-stage edge pipeline unless rsp_tready stalls
//   it. An item of n bars gives n rectangles, at most 50 per number.
//   A new number is accepted once the previous one is fully split.
// Reset: clears pipeline valids, queue and front end; dimensions return to
//   1280x720. A stalled rsp_tready holds the output and backs up the whole
//   pipeline, then the queue, then the front end.
// ----------------------------------------------------------------------------
`include "number_to_rect_rasterizer_macros.svh"

module number_to_rect_rasterizer (
   input  logic                            clock,
   input  logic                            reset,
   // number, pos_x, pos_y, digit_size, paint_color
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [nrr_pkg::REQ_DATA_W-1:0]  req_tdata,
   // col_start, col_end, row_start, row_end, rect_color
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [nrr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [nrr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import nrr_pkg::*;

   logic [DIM_W-1:0] width_ff, height_ff, wdat;
   dims_type         dims;
   logic             push, push_ready, pop, pop_valid;
   digit_entry_type  push_data, pop_data;

   // Configuration registers
   assign csr_pready = 1'b1;
   assign wdat = (csr_pwdata[DIM_W-1:0] == '0) ? 13'd1 :
                 (csr_pwdata[DIM_W-1:0] > DIM_MAX) ? DIM_MAX : csr_pwdata[DIM_W-1:0];
   assign csr_prdata = {19'd0, (csr_paddr[2] == REG_HEIGHT) ? height_ff : width_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         if (csr_paddr[2] == REG_WIDTH) width_ff <= wdat;
         else                           height_ff <= wdat;
      end
   end

   always_comb begin
      dims.width  = width_ff;
      dims.height = height_ff;
      dims.scale  = (width_ff < height_ff) ? width_ff : height_ff;
   end

   nrr_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .push, .push_data, .push_ready
   );

   nrr_queue u_queue (
      .clock, .reset, .push, .push_data, .push_ready,
      .pop, .pop_data, .pop_valid
   );

   nrr_back u_back (
      .clock, .reset, .dims,
      .entry_valid(pop_valid), .entry(pop_data), .entry_pop(pop),
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast
   );

   // Checks
   `NRR_ASSERT_NOW(a_col_clamp, clock, reset, rsp_tvalid, rsp_tdata[25:13] <= width_ff, "col_end beyond screen")
   `NRR_ASSERT_NOW(a_row_clamp, clock, reset, rsp_tvalid, rsp_tdata[51:39] <= height_ff, "row_end beyond screen")
   `NRR_ASSERT_NOW(a_dims_range, clock, reset, 1'b1, width_ff != '0 && width_ff <= DIM_MAX && height_ff != '0 && height_ff <= DIM_MAX, "dimension out of range")
   `NRR_ASSERT_NEXT(a_accept_busy, clock, reset, req_tvalid && req_tready, !req_tready, "front end not busy after accept")

endmodule

### sim/tb_number_to_rect_rasterizer.sv
// ----------------------------------------------------------------------------
// Number to rectangle rasterizer: testbench
// Sends numbers with a position, stroke size and color, predicts every
// clipped bar rectangle, and compares each returned rectangle field by field.
// Covers directed edge values, every digit, screen size extremes and random
// traffic with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_number_to_rect_rasterizer;
   timeunit 1ns;
   timeprecision 1ps;
   import nrr_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 12;

   typedef struct {
      logic [DIM_W-1:0]   col_start;
      logic [DIM_W-1:0]   col_end;
      logic [DIM_W-1:0]   row_start;
      logic [DIM_W-1:0]   row_end;
      logic [COLOR_W-1:0] color;
      logic               last;
   } rect_t;

   // Bar shapes per digit: centre offset and half extent, in half size units
   localparam int GLYPH_DX [39] = '{-2,2,0,0, 2, 0,0,0,2,-2, 2,0,0,0, 2,-2,0,
                                    0,0,0,-2,2, -2,0,0,0,2, 2,0, -2,2,0,0,0,
                                    2,0,0,0,-2};
   localparam int GLYPH_DY [39] = '{0,0,4,-4, 0, 4,-4,0,2,-2, 0,4,-4,0, 0,2,0,
                                    4,-4,0,2,-2, 0,4,-4,0,-2, 0,4, 0,0,4,-4,0,
                                    0,4,-4,0,2};
   localparam int GLYPH_HX [39] = '{1,1,1,1, 1, 3,3,3,1,1, 1,3,3,3, 1,1,3,
                                    3,3,3,1,1, 1,3,3,3,1, 1,3, 1,1,1,1,3,
                                    1,3,3,3,1};
   localparam int GLYPH_HY [39] = '{5,5,1,1, 5, 1,1,1,3,3, 5,1,1,1, 5,3,1,
                                    1,1,1,3,3, 5,1,1,1,3, 5,1, 5,5,1,1,1,
                                    5,1,1,1,3};
   localparam int GLYPH_FIRST [10] = '{0, 4, 5, 10, 14, 17, 22, 27, 29, 34};
   localparam int GLYPH_COUNT [10] = '{4, 1, 5, 4, 3, 5, 5, 2, 5, 5};

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   // number[30:0], pos_x[46:31], pos_y[62:47], digit_size[77:63],
   // paint_color[109:78], zero fill
   logic [REQ_DATA_W-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   // col_start[12:0], col_end[25:13], row_start[38:26], row_end[51:39],
   // rect_color[83:52], zero fill
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic csr_pready;

   number_to_rect_rasterizer dut (.*);

   rect_t expected_rects[$];
   int    screen_w;
   int    screen_h;
   int    error_count;
   int    numbers_sent;
   int    rects_checked;
   int    idle_cycles;
   bit    stalls_on;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------
   function automatic logic [DIM_W-1:0] edge_to_pixel(longint e, longint dim);
      longint scale;
      longint q;
      scale = (screen_w < screen_h) ? screen_w : screen_h;
      q = (e * scale + dim * 25600) / 51200;
      if (q < 0) q = 0;
      if (q > dim) q = dim;
      return q[DIM_W-1:0];
   endfunction

   task automatic predict_digits(input logic [NUMBER_W-1:0] number,
                                 input logic signed [POS_W-1:0] pos_x,
                                 input logic signed [POS_W-1:0] pos_y,
                                 input logic [SIZE_W-1:0] digit_size,
                                 input logic [COLOR_W-1:0] color);
      longint remaining;
      longint cursor;
      longint size;
      longint cx;
      longint cy;
      int     digit;
      int     g;
      bit     started;
      rect_t  r;
      remaining = number;
      cursor = 0;
      size = digit_size;
      started = 0;
      while (remaining != 0 || !started) begin
         started = 1;
         digit = remaining % 10;
         remaining = remaining / 10;
         for (int b = 0; b < GLYPH_COUNT[digit]; b++) begin
            g = GLYPH_FIRST[digit] + b;
            cx = 2 * longint'(pos_x) - cursor + GLYPH_DX[g] * size;
            cy = 2 * longint'(pos_y) + GLYPH_DY[g] * size;
            r.col_start = edge_to_pixel(cx - GLYPH_HX[g] * size, screen_w);
            r.col_end   = edge_to_pixel(cx + GLYPH_HX[g] * size, screen_w);
            r.row_start = edge_to_pixel(cy - GLYPH_HY[g] * size, screen_h);
            r.row_end   = edge_to_pixel(cy + GLYPH_HY[g] * size, screen_h);
            r.color     = color;
            r.last      = 1'b0;
            expected_rects.push_back(r);
         end
         cursor += ((digit == 1) ? 4 : 8) * size;
      end
      expected_rects[expected_rects.size() - 1].last = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string what, input longint got,
                                  input longint want);
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      rect_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rects.size() == 0) begin
            report_mismatch("unexpected rectangle", rsp_tdata[51:0], 0);
         end else begin
            want = expected_rects.pop_front();
            if (rsp_tdata[12:0] !== want.col_start)
               report_mismatch("col_start", rsp_tdata[12:0], want.col_start);
            if (rsp_tdata[25:13] !== want.col_end)
               report_mismatch("col_end", rsp_tdata[25:13], want.col_end);
            if (rsp_tdata[38:26] !== want.row_start)
               report_mismatch("row_start", rsp_tdata[38:26], want.row_start);
            if (rsp_tdata[51:39] !== want.row_end)
               report_mismatch("row_end", rsp_tdata[51:39], want.row_end);
            if (rsp_tdata[83:52] !== want.color)
               report_mismatch("rect_color", rsp_tdata[83:52], want.color);
            if (rsp_tlast !== want.last)
               report_mismatch("last_rect", rsp_tlast, want.last);
            rects_checked++;
         end
      end
   end

   // Receiver: random hold-off drawn for every rectangle
   int rsp_hold;
   always @(posedge clock) begin
      logic ready_next;
      if (reset) begin
         rsp_hold = 0;
         ready_next = 1'b1;
      end else begin
         if (rsp_tvalid && rsp_tready)
            rsp_hold = stalls_on ? $urandom_range(0, 6) : 0;
         else if (rsp_hold > 0)
            rsp_hold--;
         ready_next = (rsp_hold == 0);
      end
      rsp_tready <= ready_next;
   end

   // Watchdog on cycles with no transaction at all
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d rectangles outstanding",
                  expected_rects.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------
   task automatic send_number(input logic [NUMBER_W-1:0] number,
                              input logic [POS_W-1:0] pos_x,
                              input logic [POS_W-1:0] pos_y,
                              input logic [SIZE_W-1:0] digit_size,
                              input logic [COLOR_W-1:0] color);
      int gap;
      gap = stalls_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, color, digit_size, pos_y, pos_x, number};
      do @(posedge clock); while (!req_tready);
      predict_digits(number, pos_x, pos_y, digit_size, color);
      numbers_sent++;
   endtask

   // Hold the sender until every rectangle is back and the pipe is empty
   task automatic drain_all();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_rects.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_dim(input logic index, input logic [31:0] value);
      logic [12:0] v;
      drain_all();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      v = value[12:0];
      if (v < 1) v = 1;
      if (v > 4096) v = 4096;
      if (index == REG_WIDTH) screen_w = v;
      else screen_h = v;
   endtask

   task automatic send_random_number();
      logic [NUMBER_W-1:0] number;
      logic [POS_W-1:0]    px;
      logic [POS_W-1:0]    py;
      logic [SIZE_W-1:0]   size;
      int                  digits;
      digits = $urandom_range(1, 10);
      number = $urandom_range(0, 31'h7FFFFFFF);
      if (digits < 10) number = number % (64'd10 ** digits);
      if ($urandom_range(0, 3) == 0) begin
         px = $urandom;
         py = $urandom;
      end else begin
         px = $urandom_range(0, 8000);
         py = 16'($signed($urandom_range(0, 12000)) - 6000);
      end
      size = ($urandom_range(0, 7) == 0) ? 15'($urandom) : 15'($urandom_range(0, 900));
      send_number(number, px, py, size, $urandom);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_directed();
      for (int d = 0; d < 10; d++)
         send_number(d, 16'sd1024 * d, 16'sd0, 15'd256, 32'h1000_0000 + d);
      send_number(31'h7FFFFFFF, 16'sd0, 16'sd0, 15'd128, 32'hFFFF_FFFF);
      send_number(31'd1234567890, 16'sd6000, -16'sd2000, 15'd200, 32'h0);
      send_number(31'd11111, 16'h7FFF, 16'h7FFF, 15'd300, 32'hA5A5_5A5A);
      send_number(31'd808, 16'h8000, 16'h8000, 15'd300, 32'h5A5A_A5A5);
      send_number(31'd47, 16'sd0, 16'sd0, 15'd0, 32'h0F0F_0F0F);
      send_number(31'd2147483647, 16'h7FFF, 16'h8000, 15'h7FFF, 32'hF0F0_F0F0);
      send_number(31'd0, 16'h8000, 16'h7FFF, 15'h7FFF, 32'h1234_5678);
      send_number(31'd90, 16'sd100, 16'sd100, 15'd1, 32'h8765_4321);
   endtask

   task automatic test_screen_extremes();
      write_dim(REG_WIDTH, 32'd1);
      write_dim(REG_HEIGHT, 32'd1);
      send_number(31'd58, 16'sd0, 16'sd0, 15'd400, 32'h1);
      send_number(31'd3, 16'h8000, 16'h7FFF, 15'h7FFF, 32'h2);
      write_dim(REG_WIDTH, 32'd4096);
      write_dim(REG_HEIGHT, 32'd4096);
      send_number(31'd6029, 16'sd2000, -16'sd500, 15'd500, 32'h3);
      send_number(31'd999999999, 16'h7FFF, 16'h0, 15'h7FFF, 32'h4);
      // zero saturates up, oversize saturates down
      write_dim(REG_WIDTH, 32'd0);
      write_dim(REG_HEIGHT, 32'hFFFF_FFFF);
      send_number(31'd71, 16'sd0, 16'sd0, 15'd300, 32'h5);
      write_dim(REG_WIDTH, 32'd4097);
      write_dim(REG_HEIGHT, 32'd1);
      send_number(31'd42, 16'sd0, 16'sd0, 15'd300, 32'h6);
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 6; phase++) begin
         write_dim(REG_WIDTH, $urandom_range(1, 4096));
         write_dim(REG_HEIGHT, $urandom_range(1, 4096));
         if (phase == 5) begin
            write_dim(REG_WIDTH, 32'd1280);
            write_dim(REG_HEIGHT, 32'd720);
         end
         stalls_on = (phase != 2);
         for (int i = 0; i < 16; i++) begin
            send_random_number();
            if (i == 8) drain_all();
         end
      end
      stalls_on = 1'b1;
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b1;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      screen_w    = WIDTH_RST;
      screen_h    = HEIGHT_RST;
      error_count = 0;
      numbers_sent  = 0;
      rects_checked = 0;
      idle_cycles = 0;
      stalls_on   = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_screen_extremes();
      test_random_traffic();
      drain_all();

      if (expected_rects.size() != 0) begin
         report_mismatch("rectangles never returned", expected_rects.size(), 0);
      end
      $display("covered %0d numbers, %0d rectangles, every digit, screen 1..4096",
               numbers_sent, rects_checked);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
